[rtl/ris_pkg.sv]
// shared types and constants for the rounded integer square root
// no dependencies
package ris_pkg;

    localparam int ROOT_BITS    = 17;
    localparam int M_TDATA_BITS = ((ROOT_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ROUND
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic last_step;
    } dp_status_t;

endpackage

[rtl/ris_ctrl.sv]
// controller for the rounded integer square root: state machine and output valid
// depends on ris_pkg
module ris_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output ris_pkg::dp_cmd_t    cmd,
    input  ris_pkg::dp_status_t status
);

    ris_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ris_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ris_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ris_pkg::ST_RUN;
                end
            end
            ris_pkg::ST_RUN: begin
                cmd.step = 1'b1;
                if (status.last_step) begin
                    state_next = ris_pkg::ST_ROUND;
                end
            end
            ris_pkg::ST_ROUND: begin
                // wait for the output register to be free
                if (!out_valid_reg || m_tready) begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ris_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ris_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;

endmodule

[rtl/ris_dp.sv]
// datapath for the rounded integer square root: remainder, partial root,
// trial bit and result register; depends on ris_pkg
module ris_dp #(
    parameter int RADICAND_BITS = 32
) (
    input  logic                         aclk,
    input  logic [RADICAND_BITS-1:0]     radicand,
    input  ris_pkg::dp_cmd_t             cmd,
    output ris_pkg::dp_status_t          status,
    output logic [ris_pkg::ROOT_BITS-1:0] root
);

    localparam int TOP_SHIFT = ((RADICAND_BITS - 1) / 2) * 2;
    localparam int WIDE_BITS =
        (RADICAND_BITS > ris_pkg::ROOT_BITS) ? RADICAND_BITS : ris_pkg::ROOT_BITS;
    localparam logic [RADICAND_BITS-1:0] TOP_BIT =
        {{(RADICAND_BITS-1){1'b0}}, 1'b1} << TOP_SHIFT;

    logic [RADICAND_BITS-1:0]      rem_reg, rem_next;
    logic [RADICAND_BITS-1:0]      res_reg, res_next;
    logic [RADICAND_BITS-1:0]      bit_reg, bit_next;
    logic [ris_pkg::ROOT_BITS-1:0] root_reg, root_next;
    logic [RADICAND_BITS:0]        trial;
    logic                          fits;
    logic [WIDE_BITS-1:0]          res_wide;

    assign trial    = {1'b0, res_reg} + {1'b0, bit_reg};
    assign fits     = {1'b0, rem_reg} >= trial;
    assign res_wide = WIDE_BITS'(res_reg);

    always_comb begin
        rem_next  = rem_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        root_next = root_reg;
        if (cmd.load) begin
            rem_next = radicand;
            res_next = '0;
            bit_next = TOP_BIT;
        end else if (cmd.step) begin
            if (fits) begin
                rem_next = rem_reg - trial[RADICAND_BITS-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end else begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
        if (cmd.emit) begin
            root_next = ris_pkg::ROOT_BITS'(res_wide + WIDE_BITS'(rem_reg > res_reg));
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
        root_reg <= root_next;
    end

    assign status.last_step = bit_reg[0];
    assign root             = root_reg;

endmodule

[rtl/rounded_integer_sqrt_top.sv]
// top level of the rounded integer square root
// depends on ris_pkg, ris_ctrl and ris_dp
//
// Returns the square root of an unsigned radicand rounded to the nearest integer,
// using the restoring binary digit-by-digit method. One item at a time: after the
// transfer in, one shared subtract-and-compare unit produces one root bit per cycle,
// ((RADICAND_BITS-1)/2)+1 root bits (16 for 32 bits), then a rounding state loads
// the output register once it is free or being read. A new radicand is taken while
// the previous root waits in the output register. The result is the low 17 bits of
// the rounded root.
module rounded_integer_sqrt_top #(
    parameter int RADICAND_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((RADICAND_BITS+7)/8)*8-1:0] s_tdata,  // radicand
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ris_pkg::M_TDATA_BITS-1:0]   m_tdata   // root
);

    ris_pkg::dp_cmd_t              cmd;
    ris_pkg::dp_status_t           status;
    logic [ris_pkg::ROOT_BITS-1:0] root;

    ris_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    ris_dp #(
        .RADICAND_BITS (RADICAND_BITS)
    ) u_dp (
        .aclk     (aclk),
        .radicand (s_tdata[RADICAND_BITS-1:0]),
        .cmd      (cmd),
        .status   (status),
        .root     (root)
    );

    assign m_tdata = ris_pkg::M_TDATA_BITS'(root);

endmodule
